[src/calendar_datetime_arith_defines.svh]
// Assertion helpers shared by the date-time arithmetic block.
// Both expect clk and rst_n in the enclosing module.
`ifndef CALENDAR_DATETIME_ARITH_DEFINES_SVH
`define CALENDAR_DATETIME_ARITH_DEFINES_SVH

// Same-cycle implication.
`define CDA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cda: same-cycle check failed");

// Next-cycle implication.
`define CDA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cda: next-cycle check failed");

`endif

[src/cda_pkg.sv]
package cda_pkg;

  typedef enum logic [1:0] {
    MODE_DIFF = 2'd0,
    MODE_ADD  = 2'd1,
    MODE_SUB  = 2'd2,
    MODE_NONE = 2'd3
  } cda_mode_t;

  // Per-stage advance strobes of the day-index front end.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } cda_stage_en_t;

  localparam logic [16:0] SECS_PER_DAY = 17'd86400;
  localparam logic [17:0] SECS_TWO_DAYS = 18'd172800;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN = 6'd60;
  localparam logic [17:0] DAYS_400Y = 18'd146097;
  localparam logic [15:0] DAYS_100Y = 16'd36524;
  localparam logic [10:0] DAYS_4Y = 11'd1461;
  localparam logic [8:0]  DAYS_1Y = 9'd365;
  localparam logic [14:0] YEAR_SHIFT = 15'd399;
  localparam logic [21:0] MAX_OUT_DAYS = 22'h3FFFFF;
  // Day index of 0001-01-01 and of 10000-01-01.
  localparam logic [22:0] IDX_LO = 23'd146097;
  localparam logic [22:0] IDX_HI = 23'd3798156;

  // Scaled reciprocals for constant division.
  localparam logic [11:0] RECIP25_S16 = 12'd2622;
  localparam logic [15:0] RECIP25_S20 = 16'd41944;
  localparam logic [16:0] RECIP3600_S28 = 17'd74566;
  localparam logic [14:0] RECIP400Y_S32 = 15'd29398;  // floor, needs one correction
  localparam logic [14:0] RECIP60_S20 = 15'd17477;
  localparam logic [17:0] RECIP1461_S28 = 18'd183735;

  // Days in a common year before the first of month m (1 to 12).
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

[src/cda_day_index.sv]
module cda_day_index (
  input  logic                   clk,
  input  cda_pkg::cda_stage_en_t en,
  input  logic [13:0]            year,
  input  logic [3:0]             month,
  input  logic [4:0]             day,
  input  logic [16:0]            secs,
  output logic [22:0]            idx,
  output logic [16:0]            sec
);

  logic [3:0]  mon_nxt;
  logic [14:0] yp_nxt;
  logic [14:0] yp_r;
  logic [23:0] q25p_r;
  logic [13:0] y_r;
  logic [29:0] yq_r;
  logic [3:0]  mon1_r;
  logic [4:0]  day1_r;
  logic [16:0] sec1_r;

  logic [7:0]  q100;
  logic [9:0]  y25;
  logic        div25;
  logic        leap_nxt;
  logic [22:0] base_nxt;
  logic [22:0] base_r;
  logic        leap_r;
  logic [3:0]  mon2_r;
  logic [4:0]  day2_r;
  logic [16:0] sec2_r;

  logic        over;
  logic [23:0] idx_nxt;
  logic [16:0] sec_nxt;
  logic [22:0] idx_r;
  logic [16:0] sec_r;

  // Stage 1: clamp month, shift year, reciprocal products for /100 and %25.
  always_comb begin
    if (month == 4'd0) begin
      mon_nxt = 4'd1;
    end else if (month > 4'd12) begin
      mon_nxt = 4'd12;
    end else begin
      mon_nxt = month;
    end
    yp_nxt = {1'b0, year} + cda_pkg::YEAR_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      yp_r   <= yp_nxt;
      q25p_r <= 24'(yp_nxt[14:2]) * 24'(cda_pkg::RECIP25_S16);
      y_r    <= year;
      yq_r   <= 30'(year) * 30'(cda_pkg::RECIP25_S20);
      mon1_r <= mon_nxt;
      day1_r <= day;
      sec1_r <= secs;
    end
  end

  // Stage 2: day count of whole years, leap flag of the given year.
  always_comb begin
    q100  = q25p_r[23:16];
    y25   = yq_r[29:20];
    div25 = (y_r == 14'(14'(y25) * 14'd25));
    leap_nxt = (y_r[1:0] == 2'd0) && (!div25 || (y_r[3:0] == 4'd0));
    base_nxt = 23'(23'(yp_r) * 23'(cda_pkg::DAYS_1Y) + 23'(yp_r[14:2])
                   - 23'(q100) + 23'(q100[7:2]));
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      base_r <= base_nxt;
      leap_r <= leap_nxt;
      mon2_r <= mon1_r;
      day2_r <= day1_r;
      sec2_r <= sec1_r;
    end
  end

  // Stage 3: add month and day offsets, fold a full day of seconds.
  always_comb begin
    over = (sec2_r >= cda_pkg::SECS_PER_DAY);
    idx_nxt = 24'(base_r) + 24'(cda_pkg::cum_days(mon2_r))
              + 24'((mon2_r > 4'd2) && leap_r) + 24'(day2_r) + 24'(over) - 24'd1;
    sec_nxt = over ? 17'(sec2_r - cda_pkg::SECS_PER_DAY) : sec2_r;
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      idx_r <= idx_nxt[22:0];
      sec_r <= sec_nxt;
    end
  end

  assign idx = idx_r;
  assign sec = sec_r;

endmodule

[src/calendar_datetime_arith.sv]
// Throughput: one request per cycle unless a stalled output fills the
// pipeline; thirteen register stages of constant reciprocal multiplies
// and compares, each stage with its own valid bit.
// A stalled output holds; empty stages upstream still take requests.
// Reset (rst_n low, synchronous) clears the stage valid bits only.
`include "calendar_datetime_arith_defines.svh"

module calendar_datetime_arith (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // a_year, a_month, a_day, a_secs, b_year, b_month, b_day, b_secs, span_days, pad
  input  logic [103:0] in_tdata,
  // mode
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_days, out_year, out_month, out_day, out_hour, out_minute, out_second, pad
  output logic [63:0]  out_tdata,
  // out_of_range
  output logic [0:0]   out_tuser
);

  typedef struct packed {
    logic        diff;
    logic        oor;
    logic [21:0] days;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cda_pass_t;

  logic [12:0] stage_en;
  logic [12:0] vld_r;
  logic [12:0] vld_nxt;
  cda_pkg::cda_stage_en_t idx_en;

  logic [22:0] ida;
  logic [22:0] idb;
  logic [16:0] sa;
  logic [16:0] sb;

  cda_pkg::cda_mode_t mode1_r, mode2_r, mode3_r, mode4_r;
  logic [21:0] span1_r, span2_r, span3_r;
  logic [16:0] bs1_r, bs2_r, bs3_r;

  // stage 4
  logic [17:0] add_sum;
  logic [1:0]  add_cy;
  logic [18:0] sub_dif;
  logic [1:0]  sub_bw;
  logic [24:0] t_nxt;
  logic [16:0] ts_nxt;
  logic [23:0] dd4_r;
  logic [17:0] ds4_r;
  logic [24:0] t4_r;
  logic [16:0] ts4_r;

  // stage 5
  logic               neg;
  logic signed [23:0] dm;
  logic signed [17:0] sm;
  logic               t_oor;
  cda_pass_t          pass5_nxt;
  logic [16:0]        sec5_nxt;
  cda_pass_t          pass5_r, pass6_r, pass7_r, pass8_r, pass9_r, pass10_r;
  cda_pass_t          pass11_r, pass12_r;
  logic [16:0]        sec5_r, sec6_r;
  logic [21:0]        n5_r, n6_r;

  // stages 6 to 12
  logic [33:0] hp6_r;
  logic [36:0] qp6_r;
  logic [4:0]  h7_nxt;
  logic [4:0]  qe7_nxt;
  logic [22:0] r7_full;
  cda_pass_t   pass7_nxt;
  logic [11:0] rem7_r, rem8_r;
  logic [4:0]  qe7_r;
  logic [18:0] r7_r;
  logic        ge8;
  logic [4:0]  q8_r, q9_r, q10_r, q11_r;
  logic [17:0] r8_r;
  logic [26:0] mp8_r;
  logic [5:0]  min9_nxt;
  logic [1:0]  c9_nxt;
  cda_pass_t   pass9_nxt;
  logic [1:0]  c9_r, c10_r, c11_r;
  logic [15:0] r9_r, r10_r;
  logic [33:0] q4p10_r;
  logic [4:0]  q4_nxt;
  logic [4:0]  q4_11_r;
  logic [10:0] r11_r;
  logic [1:0]  y1_nxt;
  logic [8:0]  doy12_r;
  logic [13:0] year12_r;
  logic        leap12_r;

  // stage 13
  logic [3:0]  mon_nxt;
  logic [9:0]  thr;
  logic [9:0]  off;
  logic [4:0]  dom_nxt;
  logic [63:0] tdata_nxt;
  logic [63:0] tdata_r;
  logic        tuser_r;

  // Stage enables: a stage advances when empty or when its successor advances.
  always_comb begin
    stage_en[12] = !vld_r[12] || out_tready;
    for (int k = 11; k >= 0; k--) begin
      stage_en[k] = !vld_r[k] || stage_en[k+1];
    end
    vld_nxt[0] = stage_en[0] ? in_tvalid : vld_r[0];
    for (int k = 1; k < 13; k++) begin
      vld_nxt[k] = stage_en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready = stage_en[0];
  assign idx_en = '{s1: stage_en[0], s2: stage_en[1], s3: stage_en[2]};

  cda_day_index u_idx_a (
    .clk   (clk),
    .en    (idx_en),
    .year  (in_tdata[13:0]),
    .month (in_tdata[17:14]),
    .day   (in_tdata[22:18]),
    .secs  (in_tdata[39:23]),
    .idx   (ida),
    .sec   (sa)
  );

  cda_day_index u_idx_b (
    .clk   (clk),
    .en    (idx_en),
    .year  (in_tdata[53:40]),
    .month (in_tdata[57:54]),
    .day   (in_tdata[62:58]),
    .secs  (in_tdata[79:63]),
    .idx   (idb),
    .sec   (sb)
  );

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      mode1_r <= cda_pkg::cda_mode_t'(in_tuser);
      span1_r <= in_tdata[101:80];
      bs1_r   <= in_tdata[79:63];
    end
    if (stage_en[1]) begin
      mode2_r <= mode1_r;
      span2_r <= span1_r;
      bs2_r   <= bs1_r;
    end
    if (stage_en[2]) begin
      mode3_r <= mode2_r;
      span3_r <= span2_r;
      bs3_r   <= bs2_r;
    end
  end

  // Stage 4: raw differences, and the shifted day with second carry or borrow.
  always_comb begin
    add_sum = {1'b0, sa} + {1'b0, bs3_r};
    if (add_sum >= cda_pkg::SECS_TWO_DAYS) begin
      add_cy = 2'd2;
    end else if (add_sum >= 18'(cda_pkg::SECS_PER_DAY)) begin
      add_cy = 2'd1;
    end else begin
      add_cy = 2'd0;
    end
    sub_dif = {2'b0, sa} - {2'b0, bs3_r};
    if ($signed(sub_dif) < -19'sd86400) begin
      sub_bw = 2'd2;
    end else if ($signed(sub_dif) < 19'sd0) begin
      sub_bw = 2'd1;
    end else begin
      sub_bw = 2'd0;
    end
    if (mode3_r == cda_pkg::MODE_ADD) begin
      t_nxt  = 25'(ida) + 25'(span3_r) + 25'(add_cy);
      ts_nxt = 17'(add_sum - 18'(add_cy) * 18'(cda_pkg::SECS_PER_DAY));
    end else begin
      t_nxt  = 25'(ida) - 25'(span3_r) - 25'(sub_bw);
      ts_nxt = 17'(sub_dif + 19'(sub_bw) * 19'(cda_pkg::SECS_PER_DAY));
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      mode4_r <= mode3_r;
      dd4_r   <= 24'(ida) - 24'(idb);
      ds4_r   <= 18'(sa) - 18'(sb);
      t4_r    <= t_nxt;
      ts4_r   <= ts_nxt;
    end
  end

  // Stage 5: order the difference, range-check the shifted day.
  always_comb begin
    neg = ($signed(dd4_r) < 24'sd0) || ((dd4_r == '0) && ($signed(ds4_r) < 18'sd0));
    dm  = neg ? -$signed(dd4_r) : $signed(dd4_r);
    sm  = neg ? -$signed(ds4_r) : $signed(ds4_r);
    if (sm < 18'sd0) begin
      sm = sm + 18'sd86400;
      dm = dm - 24'sd1;
    end
    t_oor = ($signed(t4_r) < $signed({2'b0, cda_pkg::IDX_LO}))
         || ($signed(t4_r) >= $signed({2'b0, cda_pkg::IDX_HI}));
    pass5_nxt = '0;
    sec5_nxt  = '0;
    unique case (mode4_r) inside
      cda_pkg::MODE_DIFF: begin
        pass5_nxt.diff = 1'b1;
        pass5_nxt.days = (dm > 24'sd4194303) ? cda_pkg::MAX_OUT_DAYS : 22'(dm);
        sec5_nxt = 17'(sm);
      end
      cda_pkg::MODE_ADD, cda_pkg::MODE_SUB: begin
        pass5_nxt.oor = t_oor;
        sec5_nxt = ts4_r;
      end
      default: begin
        pass5_nxt.oor = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      pass5_r <= pass5_nxt;
      sec5_r  <= sec5_nxt;
      n5_r    <= 22'(t4_r - 25'(cda_pkg::IDX_LO));
    end
  end

  // Stage 6: reciprocal products for hours and 400-year cycles.
  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      pass6_r <= pass5_r;
      sec6_r  <= sec5_r;
      n6_r    <= n5_r;
      hp6_r   <= 34'(sec5_r) * 34'(cda_pkg::RECIP3600_S28);
      qp6_r   <= 37'(n5_r) * 37'(cda_pkg::RECIP400Y_S32);
    end
  end

  // Stage 7: hour, seconds within the hour, estimated cycle remainder.
  always_comb begin
    h7_nxt  = hp6_r[32:28];
    qe7_nxt = qp6_r[36:32];
    r7_full = 23'(n6_r) - 23'(qe7_nxt) * 23'(cda_pkg::DAYS_400Y);
    pass7_nxt = pass6_r;
    pass7_nxt.hour = h7_nxt;
  end

  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      pass7_r <= pass7_nxt;
      rem7_r  <= 12'(sec6_r - 17'(17'(h7_nxt) * 17'(cda_pkg::SECS_PER_HOUR)));
      qe7_r   <= qe7_nxt;
      r7_r    <= r7_full[18:0];
    end
  end

  // Stage 8: correct the low estimate, minute product.
  always_comb begin
    ge8 = (r7_r >= 19'(cda_pkg::DAYS_400Y));
  end

  always_ff @(posedge clk) begin
    if (stage_en[7]) begin
      pass8_r <= pass7_r;
      q8_r    <= qe7_r + 5'(ge8);
      r8_r    <= ge8 ? 18'(r7_r - 19'(cda_pkg::DAYS_400Y)) : r7_r[17:0];
      rem8_r  <= rem7_r;
      mp8_r   <= 27'(rem7_r) * 27'(cda_pkg::RECIP60_S20);
    end
  end

  // Stage 9: minute and second; century within the cycle.
  always_comb begin
    min9_nxt = mp8_r[25:20];
    if (r8_r >= 18'(3 * cda_pkg::DAYS_100Y)) begin
      c9_nxt = 2'd3;
    end else if (r8_r >= 18'(2 * cda_pkg::DAYS_100Y)) begin
      c9_nxt = 2'd2;
    end else if (r8_r >= 18'(cda_pkg::DAYS_100Y)) begin
      c9_nxt = 2'd1;
    end else begin
      c9_nxt = 2'd0;
    end
    pass9_nxt = pass8_r;
    pass9_nxt.minute = min9_nxt;
    pass9_nxt.second = 6'(rem8_r - 12'(12'(min9_nxt) * 12'(cda_pkg::SECS_PER_MIN)));
  end

  always_ff @(posedge clk) begin
    if (stage_en[8]) begin
      pass9_r <= pass9_nxt;
      q9_r    <= q8_r;
      c9_r    <= c9_nxt;
      r9_r    <= 16'(r8_r - 18'(c9_nxt) * 18'(cda_pkg::DAYS_100Y));
    end
  end

  // Stage 10: four-year block product.
  always_ff @(posedge clk) begin
    if (stage_en[9]) begin
      pass10_r <= pass9_r;
      q10_r    <= q9_r;
      c10_r    <= c9_r;
      r10_r    <= r9_r;
      q4p10_r  <= 34'(r9_r) * 34'(cda_pkg::RECIP1461_S28);
    end
  end

  // Stage 11: four-year block and day within it.
  always_comb begin
    q4_nxt = q4p10_r[32:28];
  end

  always_ff @(posedge clk) begin
    if (stage_en[10]) begin
      pass11_r <= pass10_r;
      q11_r    <= q10_r;
      c11_r    <= c10_r;
      q4_11_r  <= q4_nxt;
      r11_r    <= 11'(r10_r - 16'(16'(q4_nxt) * 16'(cda_pkg::DAYS_4Y)));
    end
  end

  // Stage 12: year within the block, day of year, full year and leap flag.
  always_comb begin
    if (r11_r >= 11'(3 * cda_pkg::DAYS_1Y)) begin
      y1_nxt = 2'd3;
    end else if (r11_r >= 11'(2 * cda_pkg::DAYS_1Y)) begin
      y1_nxt = 2'd2;
    end else if (r11_r >= 11'(cda_pkg::DAYS_1Y)) begin
      y1_nxt = 2'd1;
    end else begin
      y1_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[11]) begin
      pass12_r <= pass11_r;
      doy12_r  <= 9'(r11_r - 11'(11'(y1_nxt) * 11'(cda_pkg::DAYS_1Y)));
      year12_r <= 14'(14'(q11_r) * 14'd400 + 14'(c11_r) * 14'd100
                      + 14'(q4_11_r) * 14'd4 + 14'(y1_nxt) + 14'd1);
      // the century year of a block is leap only in the last century
      leap12_r <= (y1_nxt == 2'd3) && ((q4_11_r != 5'd24) || (c11_r == 2'd3));
    end
  end

  // Stage 13: month search, then pack the result.
  always_comb begin
    mon_nxt = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      thr = 10'(cda_pkg::cum_days(4'(k))) + 10'((k > 2) && leap12_r);
      if (10'(doy12_r) >= thr) begin
        mon_nxt = 4'(k);
      end
    end
    off = 10'(cda_pkg::cum_days(mon_nxt)) + 10'((mon_nxt > 4'd2) && leap12_r);
    dom_nxt = 5'(10'(doy12_r) - off + 10'd1);

    tdata_nxt = '0;
    if (!pass12_r.oor) begin
      tdata_nxt[21:0]  = pass12_r.days;
      tdata_nxt[49:45] = pass12_r.hour;
      tdata_nxt[55:50] = pass12_r.minute;
      tdata_nxt[61:56] = pass12_r.second;
      if (!pass12_r.diff) begin
        tdata_nxt[35:22] = year12_r;
        tdata_nxt[39:36] = mon_nxt;
        tdata_nxt[44:40] = dom_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[12]) begin
      tdata_r <= tdata_nxt;
      tuser_r <= pass12_r.oor;
    end
  end

  assign out_tvalid = vld_r[12];
  assign out_tdata  = tdata_r;
  assign out_tuser  = tuser_r;

  `CDA_ASSERT_IMP(a_oor_clears_fields, out_tvalid && out_tuser[0], out_tdata == '0)
  `CDA_ASSERT_IMP(a_time_in_bounds, out_tvalid,
                  (out_tdata[49:45] <= 5'd23) && (out_tdata[55:50] <= 6'd59)
                  && (out_tdata[61:56] <= 6'd59))
  `CDA_ASSERT_IMP(a_date_excludes_days, out_tvalid && (out_tdata[35:22] != '0),
                  (out_tdata[21:0] == '0) && (out_tdata[39:36] != '0)
                  && (out_tdata[44:40] != '0))
  `CDA_ASSERT_IMP(a_empty_output_ready, !out_tvalid, in_tready)
  `CDA_ASSERT_NXT(a_request_enters, in_tvalid && in_tready, vld_r[0])

endmodule
